// File: src/mqfm_pkg.sv
// ----------------------------------------------------------------------------
// mqfm_pkg
// Shared types, constants and helpers for the multi-queue FIFO manager.
// ----------------------------------------------------------------------------
package mqfm_pkg;

  // Sizing
  localparam int NUM_QUEUES    = 16;
  localparam int STORE_ENTRIES = 64;
  localparam int TAG_CHARS     = 19;
  localparam int ADDR_W        = $clog2(STORE_ENTRIES);

  // Fixed field widths
  localparam int KIND_W   = 2;
  localparam int QID_W    = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;
  localparam int MASK_W   = 16;
  localparam int TAG_BYTES = 19;
  localparam int TAG_W    = 8 * TAG_BYTES;

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_ENQ  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEQ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LIST = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOQUEUE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [QID_W-1:0]  queue_id;
    logic [63:0]       tag_chars_0_7;
    logic [63:0]       tag_chars_8_15;
    logic [23:0]       tag_chars_16_18;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  queue_count;
    logic [63:0]         out_chars_0_7;
    logic [63:0]         out_chars_8_15;
    logic [23:0]         out_chars_16_18;
    logic                last;
  } out_item_t;

  // Controller to datapath strobes
  typedef struct packed {
    logic accept;
    logic init_wr;
    logic check;
    logic res;
    logic load_out;
    logic walk_rd;
    logic walk_next;
    logic tag_rd;
    logic list_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic              init_done;
    logic [KIND_W-1:0] kind;
    logic              invalid;
    logic              empty;
    logic              full;
    logic              walk_done;
    logic              idx_zero;
    logic              out_free;
  } sts_t;

  // Zero every character from the first NUL on, and beyond TAG_CHARS
  function automatic logic [TAG_W-1:0] clean_tag(input logic [TAG_W-1:0] t);
    logic [TAG_W-1:0] r;
    logic             ended;
    r     = '0;
    ended = 1'b0;
    for (int k = 0; k < TAG_BYTES; k++) begin
      if (k >= TAG_CHARS || t[8*k +: 8] == 8'h00) ended = 1'b1;
      if (!ended) r[8*k +: 8] = t[8*k +: 8];
    end
    return r;
  endfunction

endpackage

// File: src/multi_queue_fifo_manager.sv
// Sequence: an enqueue/dequeue is accepted, checked, updated and its result
// loaded; an error result skips the update step. One transaction at a time.
// List of n entries: the chain is walked into the chain memory, then the tags
// are returned newest first, each waiting for the output register to be free.
// Reset: synchronous; a pass over all 64 entries builds the free list in the link
// memory, during which no transaction is accepted (configuration is taken).
// ----------------------------------------------------------------------------
// multi_queue_fifo_manager
// Linked-list multi-queue FIFO of tags in one shared 64-entry store.
// ----------------------------------------------------------------------------
module multi_queue_fifo_manager (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  mqfm_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output mqfm_pkg::out_item_t         out_data,
  input  logic                        cfg_we,
  input  logic [mqfm_pkg::MASK_W-1:0] cfg_wdata
);

  mqfm_pkg::cmd_t cmd;
  mqfm_pkg::sts_t sts;
  logic           in_ready;

  assign in_stall = !in_ready;

  mqfm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd)
  );

  mqfm_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_data(in_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .out_valid(out_valid),
    .out_stall(out_stall), .out_data(out_data)
  );

endmodule

// File: src/mqfm_ram.sv
// ----------------------------------------------------------------------------
// mqfm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mqfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns old data on a same-address write
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// File: src/mqfm_dp.sv
// ----------------------------------------------------------------------------
// mqfm_dp
// Datapath: tag, link and walk memories, queue head tables, free list and
// the output register.
// ----------------------------------------------------------------------------
module mqfm_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mqfm_pkg::cmd_t               cmd,
  output mqfm_pkg::sts_t               sts,
  input  mqfm_pkg::in_item_t           in_data,
  input  logic                         cfg_we,
  input  logic [mqfm_pkg::MASK_W-1:0]  cfg_wdata,
  output logic                         out_valid,
  input  logic                         out_stall,
  output mqfm_pkg::out_item_t          out_data
);

  localparam int AW = mqfm_pkg::ADDR_W;
  localparam int CW = mqfm_pkg::COUNT_W;

  // Latched transaction and queue mask
  logic [mqfm_pkg::KIND_W-1:0]  kind_r;
  logic [mqfm_pkg::QID_W-1:0]   qid_r;
  logic [mqfm_pkg::TAG_W-1:0]   tag_r;
  logic [mqfm_pkg::MASK_W-1:0]  mask_r;

  // Queue tables and free list
  logic [CW-1:0] qlen_r   [mqfm_pkg::NUM_QUEUES];
  logic [AW-1:0] newest_r [mqfm_pkg::NUM_QUEUES];
  logic [AW-1:0] oldest_r [mqfm_pkg::NUM_QUEUES];
  logic [AW-1:0] free_head_r;
  logic [CW-1:0] used_r;
  logic [AW-1:0] init_cnt_r;

  // Walk state
  logic [AW-1:0] cur_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] len_r;
  logic [AW-1:0] idx_r;

  // Pending single result
  logic [mqfm_pkg::STATUS_W-1:0] res_status_r;
  logic [CW-1:0]                 res_count_r;
  logic [mqfm_pkg::TAG_W-1:0]    res_tag_r;

  logic                out_valid_r;
  mqfm_pkg::out_item_t out_r;

  // Memory ports
  logic                       link_we, tag_we;
  logic [AW-1:0]              link_waddr, link_wdata, link_raddr, link_rdata;
  logic [AW-1:0]              tag_raddr, chain_rdata;
  logic [mqfm_pkg::TAG_W-1:0] tag_rdata;

  logic [CW-1:0] qlen_cur;
  logic [AW-1:0] q_oldest, q_newest;
  logic          invalid, empty, full, enq_ok, deq_ok, list_ok;
  logic [AW-1:0] init_next;

  assign qlen_cur = qlen_r[qid_r];
  assign q_oldest = oldest_r[qid_r];
  assign q_newest = newest_r[qid_r];

  // Queue checks
  assign invalid = (qid_r == '0)
                || ({1'b0, qid_r} >= (mqfm_pkg::QID_W+1)'(mqfm_pkg::NUM_QUEUES))
                || !mask_r[qid_r];
  assign empty   = (qlen_cur == '0);
  assign full    = (used_r == CW'(mqfm_pkg::STORE_ENTRIES));
  assign enq_ok  = cmd.check && kind_r == mqfm_pkg::KIND_ENQ && !invalid && !full;
  assign deq_ok  = cmd.check && kind_r == mqfm_pkg::KIND_DEQ && !invalid && !empty;
  assign list_ok = cmd.check && kind_r == mqfm_pkg::KIND_LIST && !invalid && !empty;

  assign init_next = (init_cnt_r == AW'(mqfm_pkg::STORE_ENTRIES - 1)) ? '0
                   : init_cnt_r + 1'b1;

  // Link memory: reset pass, enqueue append, dequeue return to free list
  always_comb begin
    link_we    = cmd.init_wr || deq_ok || (enq_ok && !empty);
    link_waddr = cmd.init_wr ? init_cnt_r : (enq_ok ? q_newest : q_oldest);
    link_wdata = cmd.init_wr ? init_next : free_head_r;
    if (cmd.walk_rd)                       link_raddr = cur_r;
    else if (kind_r == mqfm_pkg::KIND_ENQ) link_raddr = free_head_r;
    else                                   link_raddr = q_oldest;
  end

  assign tag_we    = enq_ok;
  assign tag_raddr = cmd.tag_rd ? chain_rdata : q_oldest;

  mqfm_ram #(.WIDTH(AW), .DEPTH(mqfm_pkg::STORE_ENTRIES)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .re(1'b1), .raddr(link_raddr), .rdata(link_rdata)
  );

  mqfm_ram #(.WIDTH(mqfm_pkg::TAG_W), .DEPTH(mqfm_pkg::STORE_ENTRIES)) u_tag (
    .clk(clk), .we(tag_we), .waddr(free_head_r), .wdata(tag_r),
    .re(cmd.tag_rd || cmd.check), .raddr(tag_raddr), .rdata(tag_rdata)
  );

  mqfm_ram #(.WIDTH(AW), .DEPTH(mqfm_pkg::STORE_ENTRIES)) u_chain (
    .clk(clk), .we(cmd.walk_rd), .waddr(cnt_r[AW-1:0]), .wdata(cur_r),
    .re(1'b1), .raddr(idx_r), .rdata(chain_rdata)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      free_head_r <= '0;
      used_r      <= '0;
      init_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      for (int q = 0; q < mqfm_pkg::NUM_QUEUES; q++) qlen_r[q] <= '0;
    end else begin
      if (cfg_we) mask_r <= cfg_wdata;
      if (cmd.init_wr) init_cnt_r <= init_cnt_r + 1'b1;
      if (enq_ok) begin
        qlen_r[qid_r] <= qlen_cur + 1'b1;
        used_r        <= used_r + 1'b1;
      end
      if (deq_ok) begin
        qlen_r[qid_r] <= qlen_cur - 1'b1;
        used_r        <= used_r - 1'b1;
        free_head_r   <= q_oldest;
      end
      if (cmd.res && kind_r == mqfm_pkg::KIND_ENQ) free_head_r <= link_rdata;
      if (cmd.load_out || cmd.list_out) out_valid_r <= 1'b1;
      else if (!out_stall)              out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r <= in_data.kind;
      qid_r  <= in_data.queue_id;
      tag_r  <= mqfm_pkg::clean_tag({in_data.tag_chars_16_18, in_data.tag_chars_8_15,
                                     in_data.tag_chars_0_7});
    end
    if (enq_ok) begin
      if (empty) oldest_r[qid_r] <= free_head_r;
      newest_r[qid_r] <= free_head_r;
    end
    if (cmd.res && kind_r == mqfm_pkg::KIND_DEQ) begin
      oldest_r[qid_r] <= link_rdata;
      res_tag_r       <= tag_rdata;
    end
    // Result of the check step
    if (cmd.check) begin
      len_r     <= qlen_cur;
      res_tag_r <= '0;
      if (invalid) begin
        res_status_r <= mqfm_pkg::ST_NOQUEUE;
        res_count_r  <= '0;
      end else if (kind_r == mqfm_pkg::KIND_ENQ) begin
        res_status_r <= full ? mqfm_pkg::ST_FULL : mqfm_pkg::ST_OK;
        res_count_r  <= full ? qlen_cur : qlen_cur + 1'b1;
      end else begin
        res_status_r <= empty ? mqfm_pkg::ST_EMPTY : mqfm_pkg::ST_OK;
        res_count_r  <= empty ? '0 : qlen_cur - 1'b1;
      end
    end
    // Chain walk, oldest first
    if (list_ok) begin
      cur_r <= q_oldest;
      cnt_r <= '0;
    end
    if (cmd.walk_rd) cnt_r <= cnt_r + 1'b1;
    if (cmd.walk_next) begin
      cur_r <= link_rdata;
      idx_r <= AW'(len_r - 1'b1);
    end
    if (cmd.list_out) idx_r <= idx_r - 1'b1;
    // Output register
    if (cmd.load_out) begin
      out_r.status          <= res_status_r;
      out_r.queue_count     <= res_count_r;
      out_r.out_chars_0_7   <= res_tag_r[63:0];
      out_r.out_chars_8_15  <= res_tag_r[127:64];
      out_r.out_chars_16_18 <= res_tag_r[151:128];
      out_r.last            <= 1'b1;
    end else if (cmd.list_out) begin
      out_r.status          <= mqfm_pkg::ST_OK;
      out_r.queue_count     <= len_r;
      out_r.out_chars_0_7   <= tag_rdata[63:0];
      out_r.out_chars_8_15  <= tag_rdata[127:64];
      out_r.out_chars_16_18 <= tag_rdata[151:128];
      out_r.last            <= (idx_r == '0);
    end
  end

  // Status to controller
  assign sts.init_done = (init_cnt_r == AW'(mqfm_pkg::STORE_ENTRIES - 1));
  assign sts.kind      = kind_r;
  assign sts.invalid   = invalid;
  assign sts.empty     = empty;
  assign sts.full      = full;
  assign sts.walk_done = (cnt_r == len_r);
  assign sts.idx_zero  = (idx_r == '0);
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: src/mqfm_ctrl.sv
// ----------------------------------------------------------------------------
// mqfm_ctrl
// Controller: sequences reset link pass, check, update, list walk and
// result hand-off.
// ----------------------------------------------------------------------------
module mqfm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  mqfm_pkg::sts_t sts,
  output mqfm_pkg::cmd_t cmd
);

  typedef enum logic [9:0] {
    S_INIT   = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_CHECK  = 10'b0000000100,
    S_RES    = 10'b0000001000,
    S_EMIT   = 10'b0000010000,
    S_LREAD  = 10'b0000100000,
    S_LNEXT  = 10'b0001000000,
    S_LCHAIN = 10'b0010000000,
    S_LTAG   = 10'b0100000000,
    S_LOUT   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_INIT;
    else        state_r <= state_nxt;
  end

  // Next state and strobes
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (sts.init_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.kind == mqfm_pkg::KIND_NONE) state_nxt = S_IDLE;
        else if (sts.invalid) state_nxt = S_EMIT;
        else if (sts.kind == mqfm_pkg::KIND_ENQ) state_nxt = sts.full ? S_EMIT : S_RES;
        else if (sts.empty) state_nxt = S_EMIT;
        else if (sts.kind == mqfm_pkg::KIND_DEQ) state_nxt = S_RES;
        else state_nxt = S_LREAD;
      end
      S_RES: begin
        cmd.res   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_LREAD: begin
        cmd.walk_rd = 1'b1;
        state_nxt   = S_LNEXT;
      end
      S_LNEXT: begin
        cmd.walk_next = 1'b1;
        state_nxt     = sts.walk_done ? S_LCHAIN : S_LREAD;
      end
      S_LCHAIN: state_nxt = S_LTAG;
      S_LTAG: begin
        cmd.tag_rd = 1'b1;
        state_nxt  = S_LOUT;
      end
      S_LOUT: begin
        if (sts.out_free) begin
          cmd.list_out = 1'b1;
          state_nxt    = sts.idx_zero ? S_IDLE : S_LCHAIN;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

endmodule

// File: src/mqfm_checker.sv
// ----------------------------------------------------------------------------
// mqfm_checker
// Port-level checks on the multi-queue FIFO manager.
// ----------------------------------------------------------------------------
module mqfm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input mqfm_pkg::out_item_t         out_data
);

  // Held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // One transaction in flight at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted back to back");

  // Error results are single and their tag chars 0-7 and 16-18 are zero
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != mqfm_pkg::ST_OK |->
      out_data.last && out_data.out_chars_0_7 == '0 && out_data.out_chars_16_18 == '0)
    else $error("error result malformed");

  // Unknown queue reports zero count
  a_noq_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == mqfm_pkg::ST_NOQUEUE |-> out_data.queue_count == '0)
    else $error("no-queue count not zero");

endmodule

bind multi_queue_fifo_manager mqfm_checker u_mqfm_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
